@@ sv/gde_pkg.sv @@
package gde_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MEAN_VALUE   = 2'd0,
        REG_INV_STD      = 2'd1,
        REG_PEAK_DENSITY = 2'd2
    } t_reg_idx;

    // Fixed-point constants (Q2.30 for exp values)
    localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_Q30  = 64'h0000_0000_2000_0000;
    localparam logic [63:0] ONE_Q31   = 64'h0000_0000_8000_0000;
    localparam logic [47:0] AZ_LIMIT  = 48'h00_0000_80_0000;
    localparam int unsigned EXP_TERMS = 20;

    // Taylor series of exp(-y), y in Q1.31 (0..1.0), result in Q1.31.
    // Positive and negative terms are summed apart; result clamps at zero.
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = ONE_Q31;
        pos  = ONE_Q31;
        neg  = '0;
        for (int unsigned k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * y) >> 31) / 64'(k);
            if (k[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (neg > pos) ? 64'd0 : pos - neg;
    endfunction

    // Fraction table entry: exp(-k / 2^fb) in Q2.30
    function automatic logic [30:0] frac_entry(input int unsigned k, input int unsigned fb);
        logic [63:0] v;
        v = (exp_neg_q31(64'(k) << (31 - fb)) + 64'd1) >> 1;
        return v[30:0];
    endfunction

    // Integer-part table entry: exp(-n) in Q2.30, built by repeated rounded products
    function automatic logic [30:0] int_entry(input int unsigned n);
        logic [63:0] e1;
        logic [63:0] v;
        e1 = (exp_neg_q31(ONE_Q31) + 64'd1) >> 1;
        v  = ONE_Q30;
        for (int unsigned i = 1; i <= n; i++) begin
            v = (v * e1 + HALF_Q30) >> 30;
        end
        return v[30:0];
    endfunction

endpackage

@@ sv/gaussian_density_eval_core.sv @@
// Normal density evaluator: for each signed Q16.16 sample on the slave stream it returns
// peak_density * exp(-z*z/2), z = (x - mean_value) * inv_std, as unsigned Q16.16 on the
// master stream, with tuser set (and density zero) when the integer part of z*z/2 reaches
// EXP_CUTOFF. One sample is accepted per clock while the master side does not stall. The
// pipeline has 12 register stages; the input transaction loads the first one and the
// output valid comes from the last one.
// The stages carry three 32x32-class multiplies (distance scaling, squaring, peak
// scaling), one 31x31 multiply (integer-part times fraction factor) and a two-bank
// constant table lookup, each with a register behind it. Stalls on the master side back
// up stage by stage; bubbles collapse.
// Configuration registers are written through the plain write port; the user writes them
// only while the pipeline is empty (the block does not enforce it). A write to index 3 is ignored.
module gaussian_density_eval_core
    import gde_pkg::*;
#(
    parameter int FRAC_TABLE_BITS = 8,
    parameter int EXP_CUTOFF      = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // [31:0] sample_x
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,    // [31:0] density
    output logic        o_m_axis_tuser     // [0] beyond_cutoff
);

    localparam int NSTG     = 12;
    localparam int REM_BITS = 16 - FRAC_TABLE_BITS;
    localparam int HALF_N   = 2 ** (FRAC_TABLE_BITS - 1);
    localparam int EVEN_N   = HALF_N + 1;
    localparam int EVEN_AW  = $clog2(EVEN_N);
    localparam int ODD_AW   = FRAC_TABLE_BITS - 1;
    localparam int INT_AW   = $clog2(EXP_CUTOFF);
    localparam int INT_N    = 2 ** INT_AW;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [31:0] r_mean;
    logic [31:0] r_inv;
    logic [31:0] r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= 32'd0;
            r_inv  <= 32'd65536;
            r_peak <= 32'd26145;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MEAN_VALUE:   r_mean <= i_cfg_data;
                REG_INV_STD:      r_inv  <= i_cfg_data;
                REG_PEAK_DENSITY: r_peak <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Constant tables: fraction table split into even/odd banks so that the
    // two neighbors of an interpolation come from different banks.
    logic [30:0] w_frac_even [EVEN_N];
    logic [30:0] w_frac_odd  [HALF_N];
    logic [30:0] w_int_tab   [INT_N];

    for (genvar j = 0; j < EVEN_N; j++) begin : g_even
        assign w_frac_even[j] = frac_entry(2 * j, FRAC_TABLE_BITS);
    end
    for (genvar j = 0; j < HALF_N; j++) begin : g_odd
        assign w_frac_odd[j] = frac_entry(2 * j + 1, FRAC_TABLE_BITS);
    end
    for (genvar j = 0; j < INT_N; j++) begin : g_int
        assign w_int_tab[j] = int_entry(j);
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when empty or when the next one moves
    logic r_vld [NSTG];
    logic w_rdy [NSTG];

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_rdy[0];

    // ------------------------------------------------------------------
    // Pipeline payload
    logic signed [32:0] r_d,  n_d;
    logic [31:0]        r_ad, n_ad;
    logic [63:0]        r_prod, n_prod;
    logic [23:0]        r_az, n_az;
    logic [29:0]        r_t,  n_t;
    logic [30:0]        r_lk_a, n_lk_a, r_lk_b, n_lk_b, r_lk_iv, n_lk_iv;
    logic [REM_BITS-1:0] r_lk_rem, n_lk_rem;
    logic               r_lk_cut, n_lk_cut;
    logic [30:0]        r_ip_diff, n_ip_diff, r_ip_a, r_ip_iv;
    logic               r_ip_sub, n_ip_sub, r_ip_cut;
    logic [REM_BITS-1:0] r_ip_rem;
    logic [30:0]        r_fv, n_fv, r_fv_iv;
    logic               r_fv_cut;
    logic [61:0]        r_ep, n_ep;
    logic               r_ep_cut;
    logic [30:0]        r_ex, n_ex;
    logic               r_ex_cut;
    logic [62:0]        r_dp, n_dp;
    logic               r_dp_cut;
    logic [31:0]        r_out_density, n_out_density;
    logic               r_out_cut;

    // intermediate nets
    logic signed [32:0]       w_neg_d;
    logic [47:0]              w_az_full;
    logic [47:0]              w_sq;
    logic [13:0]              w_n;
    logic [FRAC_TABLE_BITS-1:0] w_idx;
    logic [ODD_AW-1:0]        w_half;
    logic [EVEN_AW-1:0]       w_even_addr;
    logic [30:0]              w_ev, w_od;
    logic [31+REM_BITS-1:0]   w_step_full;
    logic [30:0]              w_step;
    logic [61:0]              w_ep_rnd;
    logic [62:0]              w_dp_rnd;

    always_comb begin
        // distance to the mean, exact
        n_d = {i_s_axis_tdata[31], i_s_axis_tdata} - {r_mean[31], r_mean};

        // magnitude always fits 32 bits
        w_neg_d = 33'sd0 - r_d;
        n_ad    = r_d[32] ? w_neg_d[31:0] : r_d[31:0];

        // scale by 1/sigma
        n_prod = r_ad * r_inv;

        // truncate to Q16.16 and saturate at z = 128
        w_az_full = r_prod[63:16];
        n_az      = (w_az_full > AZ_LIMIT) ? AZ_LIMIT[23:0] : w_az_full[23:0];

        // t = z*z/2
        w_sq = r_az * r_az;
        n_t  = w_sq[46:17];

        // cutoff check and table lookups
        w_n         = r_t[29:16];
        w_idx       = r_t[15:REM_BITS];
        w_half      = w_idx[FRAC_TABLE_BITS-1:1];
        w_even_addr = EVEN_AW'(w_half) + EVEN_AW'(w_idx[0]);
        w_ev        = w_frac_even[w_even_addr];
        w_od        = w_frac_odd[w_half];
        n_lk_a      = w_idx[0] ? w_od : w_ev;
        n_lk_b      = w_idx[0] ? w_ev : w_od;
        n_lk_rem    = r_t[REM_BITS-1:0];
        n_lk_iv     = w_int_tab[w_n[INT_AW-1:0]];
        n_lk_cut    = (w_n >= 14'(EXP_CUTOFF));

        // interpolation direction and span
        n_ip_sub  = (r_lk_a >= r_lk_b);
        n_ip_diff = n_ip_sub ? r_lk_a - r_lk_b : r_lk_b - r_lk_a;

        // interpolated fraction factor, step truncated
        w_step_full = r_ip_diff * r_ip_rem;
        w_step      = w_step_full[31+REM_BITS-1:REM_BITS];
        n_fv        = r_ip_sub ? r_ip_a - w_step : r_ip_a + w_step;

        // integer-part factor times fraction factor
        n_ep = r_fv_iv * r_fv;

        // round back to Q2.30
        w_ep_rnd = r_ep + HALF_Q30[61:0];
        n_ex     = w_ep_rnd[60:30];

        // scale by the peak
        n_dp = r_peak * r_ex;

        // round to Q16.16; cutoff forces zero
        w_dp_rnd      = r_dp + HALF_Q30[62:0];
        n_out_density = r_dp_cut ? 32'd0 : w_dp_rnd[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) r_d <= n_d;
        if (w_rdy[1]) r_ad <= n_ad;
        if (w_rdy[2]) r_prod <= n_prod;
        if (w_rdy[3]) r_az <= n_az;
        if (w_rdy[4]) r_t <= n_t;
        if (w_rdy[5]) begin
            r_lk_a   <= n_lk_a;
            r_lk_b   <= n_lk_b;
            r_lk_rem <= n_lk_rem;
            r_lk_iv  <= n_lk_iv;
            r_lk_cut <= n_lk_cut;
        end
        if (w_rdy[6]) begin
            r_ip_diff <= n_ip_diff;
            r_ip_sub  <= n_ip_sub;
            r_ip_a    <= r_lk_a;
            r_ip_rem  <= r_lk_rem;
            r_ip_iv   <= r_lk_iv;
            r_ip_cut  <= r_lk_cut;
        end
        if (w_rdy[7]) begin
            r_fv     <= n_fv;
            r_fv_iv  <= r_ip_iv;
            r_fv_cut <= r_ip_cut;
        end
        if (w_rdy[8]) begin
            r_ep     <= n_ep;
            r_ep_cut <= r_fv_cut;
        end
        if (w_rdy[9]) begin
            r_ex     <= n_ex;
            r_ex_cut <= r_ep_cut;
        end
        if (w_rdy[10]) begin
            r_dp     <= n_dp;
            r_dp_cut <= r_ex_cut;
        end
        if (w_rdy[11]) begin
            r_out_density <= n_out_density;
            r_out_cut     <= r_dp_cut;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = r_out_density;
    assign o_m_axis_tuser  = r_out_cut;

    // ------------------------------------------------------------------
    // Assertions

    // an accepted sample always occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted sample missing from first stage");

    // cutoff flag means zero density
    a_cut_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 32'd0))
        else $error("nonzero density with cutoff flag");

    // exp(-t) never exceeds one, so density never exceeds the peak
    a_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata <= r_peak))
        else $error("density above peak");

endmodule
